>>> rtl/sfs_pkg.sv
// sfs_pkg: shared types, codes and helper functions of the sprite flipbook sequencer.
// Used by the channel interfaces and the sequencer top level; no dependencies.
`timescale 1ns / 1ps

package sfs_pkg;

   // Fixed field widths
   localparam int FRAME_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int ATLAS_W     = 13;
   localparam int TPF_W       = 24;
   localparam int DIM_W       = 7;
   localparam int CELL_W      = 6;
   localparam int OP_W        = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_W       = 24;
   localparam int FRAME_LIMIT = 4096;
   localparam int DIM_LIMIT   = 64;

   // Request operation codes; the remaining codes are no-ops
   typedef enum logic [OP_W-1:0] {
      OP_TICK      = 3'd0,
      OP_PLAY      = 3'd1,
      OP_PAUSE     = 3'd2,
      OP_STOP      = 3'd3,
      OP_SET_FRAME = 3'd4
   } op_type;

   // Register indexes of the CSR port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_COUNT     = 3'd0,
      CSR_FIRST_FRAME     = 3'd1,
      CSR_INITIAL_FRAME   = 3'd2,
      CSR_LOOP_ENABLE     = 3'd3,
      CSR_TICKS_PER_FRAME = 3'd4,
      CSR_SHEET_COLUMNS   = 3'd5,
      CSR_SHEET_ROWS      = 3'd6
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TIME,
      ST_DIV_WRAP,
      ST_LOAD_CELL,
      ST_DIV_CELL,
      ST_RESP
   } state_type;

   // Configuration register file
   typedef struct packed {
      logic [COUNT_W-1:0] frame_count;
      logic [FRAME_W-1:0] first_frame;
      logic [FRAME_W-1:0] initial_frame;
      logic               loop_enable;
      logic [TPF_W-1:0]   ticks_per_frame;
      logic [DIM_W-1:0]   sheet_columns;
      logic [DIM_W-1:0]   sheet_rows;
   } cfg_type;

   // Frame count with zero read as one and the top clipped
   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] c;
      c = count;
      if (c == '0) c = COUNT_W'(1);
      if (c > COUNT_W'(FRAME_LIMIT)) c = COUNT_W'(FRAME_LIMIT);
      return c;
   endfunction

   // Clamp a frame number to the last frame of the animation
   function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] f,
                                                      input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] last;
      last = eff_count(count) - COUNT_W'(1);
      return (COUNT_W'(f) > last) ? last[FRAME_W-1:0] : f;
   endfunction

   // Sheet dimension clipped to the largest sheet side
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      return (d > DIM_W'(DIM_LIMIT)) ? DIM_W'(DIM_LIMIT) : d;
   endfunction

endpackage

>>> rtl/sfs_if.sv
// sfs_req_if / sfs_rsp_if: valid/ready request and response channels of the sequencer.
// Depends on sfs_pkg for the field widths.
`timescale 1ns / 1ps

interface sfs_req_if
   import sfs_pkg::*;
#(
   parameter int DELTA_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [DELTA_BITS-1:0] tick_delta;
   logic [FRAME_W-1:0]    frame_request;

   modport source (output valid, output op, output tick_delta, output frame_request,
                   input ready);
   modport sink   (input valid, input op, input tick_delta, input frame_request,
                   output ready);
endinterface

interface sfs_rsp_if
   import sfs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame_now;
   logic [ATLAS_W-1:0] atlas_index;
   logic [CELL_W-1:0]  cell_column;
   logic [CELL_W-1:0]  cell_row;
   logic               is_playing;
   logic               sheet_valid;
   logic               frame_changed;

   modport source (output valid, output frame_now, output atlas_index, output cell_column,
                   output cell_row, output is_playing, output sheet_valid,
                   output frame_changed, input ready);
   modport sink   (input valid, input frame_now, input atlas_index, input cell_column,
                   input cell_row, input is_playing, input sheet_valid,
                   input frame_changed, output ready);
endinterface

>>> rtl/sprite_flipbook_frame_sequencer_top.sv
// Sprite flipbook frame sequencer: play/pause/stop/set-frame/tick control of a sprite-sheet
// animation, one shared restoring divider under a small state machine.
// Depends on sfs_pkg and the sfs_req_if / sfs_rsp_if channel interfaces.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------------------
//  req_ch  | in        | valid / ready        | op, tick_delta, frame_request
//  rsp_ch  | out       | valid / ready        | frame_now, atlas_index, cell_column, cell_row,
//          |           |                      | is_playing, sheet_valid, frame_changed
//  csr_*   | in        | csr_we, no back-pres | csr_index, csr_wdata
//
// One request is in flight at a time; req_ch.ready is high only in the idle state.
// Every request ends with the cell division; a tick that counts (playing, valid sheet,
// count above one, nonzero period) first runs the time division, and when it advances in
// loop mode also the wrap division.
// All three divisions share the one divider: accumulator / period, (frame + n) mod count,
// then atlas / columns. The response sits in an output register, so a new request is
// taken while the previous response waits; a stalled response holds only the last state.
// Reset is synchronous, active high, and clears state and configuration at once.
`timescale 1ns / 1ps

module sprite_flipbook_frame_sequencer_top
   import sfs_pkg::*;
#(
   parameter int MAX_CELLS  = 4096,
   parameter int DELTA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   sfs_req_if.sink              req_ch,
   sfs_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Accumulator holds period - 1 plus one delta; divider dividend covers frame + n
   localparam int ACC_W   = ((DELTA_BITS > TPF_W) ? DELTA_BITS : TPF_W) + 1;
   localparam int DW      = ACC_W + 1;
   localparam int RW      = TPF_W + 1;
   localparam int CNT_W   = $clog2(DW + 1);
   localparam int MAXC_W  = $clog2(MAX_CELLS + 1);
   localparam int CMP_W   = (MAXC_W > ATLAS_W) ? MAXC_W : ATLAS_W;
   localparam logic [CMP_W-1:0] MAX_CELLS_C = CMP_W'(MAX_CELLS);

   // Sheet fits: nonzero sides and first_frame + count within the capped cell count
   function automatic logic sheet_ok(input cfg_type c);
      logic [DIM_W-1:0]   cols;
      logic [DIM_W-1:0]   rows;
      logic [ATLAS_W-1:0] cells;
      logic [ATLAS_W-1:0] need;
      cols  = eff_dim(c.sheet_columns);
      rows  = eff_dim(c.sheet_rows);
      cells = ATLAS_W'(cols) * ATLAS_W'(rows);
      need  = ATLAS_W'(c.first_frame) + eff_count(c.frame_count);
      return (cols != '0) && (rows != '0) && (need <= cells) &&
             (CMP_W'(need) <= MAX_CELLS_C);
   endfunction

   // Registers
   state_type          st_ff, st_in;
   cfg_type            cfg_ff, cfg_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [FRAME_W-1:0] before_ff, before_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               playing_ff, playing_in;
   logic [DW-1:0]      dvd_ff, dvd_in;
   logic [DW-1:0]      quo_ff, quo_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [TPF_W-1:0]   dsr_ff, dsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [ATLAS_W-1:0] rsp_atlas_ff, rsp_atlas_in;
   logic [CELL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CELL_W-1:0]  rsp_row_ff, rsp_row_in;
   logic               rsp_play_ff, rsp_play_in;
   logic               rsp_sheet_ff, rsp_sheet_in;
   logic               rsp_chg_ff, rsp_chg_in;

   // Combinational helpers
   logic                  csr_hit;
   logic                  req_fire;
   logic                  cur_valid;
   logic [COUNT_W-1:0]    cur_count;
   logic [FRAME_W-1:0]    last_frame;
   logic [DIM_W-1:0]      cur_cols;
   logic [ATLAS_W-1:0]    atlas;
   logic [DELTA_BITS-1:0] delta;
   logic [ACC_W-1:0]      acc_sum;
   logic                  tick_go;
   logic [DW-1:0]         adv;
   logic [FRAME_W-1:0]    play_frame;
   logic [RW-1:0]         rem_shift;
   logic [RW-1:0]         rem_sub;
   logic                  take;
   logic                  rsp_free;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign cur_valid  = sheet_ok(cfg_ff);
   assign cur_count  = eff_count(cfg_ff.frame_count);
   assign last_frame = FRAME_W'(cur_count - COUNT_W'(1));
   assign cur_cols   = eff_dim(cfg_ff.sheet_columns);
   assign atlas      = ATLAS_W'(cfg_ff.first_frame) + ATLAS_W'(frame_ff);
   assign delta      = req_ch.tick_delta[DELTA_BITS-1:0];
   assign acc_sum    = acc_ff + ACC_W'(delta);
   assign adv        = DW'(frame_ff) + quo_ff;
   assign play_frame = clamp_frame(frame_ff, cfg_ff.frame_count);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   // A tick only counts while playing on a usable sheet with a real period
   assign tick_go = playing_ff && (delta != '0) && cur_valid &&
                    (cur_count > COUNT_W'(1)) && (cfg_ff.ticks_per_frame != '0);

   // Divider step: shift in one dividend bit, subtract when it fits
   assign rem_shift = {rem_ff[RW-2:0], dvd_ff[DW-1]};
   assign rem_sub   = rem_shift - {1'b0, dsr_ff};
   assign take      = rem_shift >= {1'b0, dsr_ff};

   // CSR decode into the next register file
   always_comb begin
      cfg_in  = cfg_ff;
      csr_hit = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_COUNT: begin
               cfg_in.frame_count = csr_wdata[COUNT_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_FIRST_FRAME: begin
               cfg_in.first_frame = csr_wdata[FRAME_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_INITIAL_FRAME: begin
               cfg_in.initial_frame = csr_wdata[FRAME_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_LOOP_ENABLE: begin
               cfg_in.loop_enable = csr_wdata[0];
               csr_hit = 1'b1;
            end
            CSR_TICKS_PER_FRAME: begin
               cfg_in.ticks_per_frame = csr_wdata[TPF_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_SHEET_COLUMNS: begin
               cfg_in.sheet_columns = csr_wdata[DIM_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_SHEET_ROWS: begin
               cfg_in.sheet_rows = csr_wdata[DIM_W-1:0];
               csr_hit = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               st_in = ((req_ch.op == OP_TICK) && tick_go) ? ST_DIV_TIME : ST_LOAD_CELL;
            end
         end
         ST_DIV_TIME: begin
            if (cnt_ff == '0) begin
               st_in = ((quo_ff != '0) && cfg_ff.loop_enable) ? ST_DIV_WRAP : ST_LOAD_CELL;
            end
         end
         ST_DIV_WRAP: begin
            if (cnt_ff == '0) st_in = ST_LOAD_CELL;
         end
         ST_LOAD_CELL: st_in = ST_DIV_CELL;
         ST_DIV_CELL: begin
            if (cnt_ff == '0) st_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Datapath and response register updates
   always_comb begin
      frame_in     = frame_ff;
      before_in    = before_ff;
      acc_in       = acc_ff;
      playing_in   = playing_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_frame_in = rsp_frame_ff;
      rsp_atlas_in = rsp_atlas_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_play_in  = rsp_play_ff;
      rsp_sheet_in = rsp_sheet_ff;
      rsp_chg_in   = rsp_chg_ff;

      case (st_ff)
         // Accept a request and apply the immediate part of the operation
         ST_IDLE: begin
            if (req_fire) begin
               before_in = frame_ff;
               case (req_ch.op)
                  OP_TICK: begin
                     if (tick_go) begin
                        acc_in = acc_sum;
                        dvd_in = {acc_sum, 1'b0};
                        quo_in = '0;
                        rem_in = '0;
                        dsr_in = cfg_ff.ticks_per_frame;
                        cnt_in = CNT_W'(ACC_W);
                     end
                  end
                  OP_PLAY: begin
                     // finished one-shot restarts from frame zero
                     if (cur_valid && !cfg_ff.loop_enable &&
                         (COUNT_W'(play_frame) + COUNT_W'(1) >= cur_count)) begin
                        frame_in = '0;
                        acc_in   = '0;
                     end else begin
                        frame_in = play_frame;
                     end
                     playing_in = 1'b1;
                  end
                  OP_PAUSE: playing_in = 1'b0;
                  OP_STOP: begin
                     playing_in = 1'b0;
                     acc_in     = '0;
                     frame_in   = clamp_frame(cfg_ff.initial_frame, cfg_ff.frame_count);
                  end
                  OP_SET_FRAME: begin
                     acc_in   = '0;
                     frame_in = clamp_frame(req_ch.frame_request, cfg_ff.frame_count);
                  end
                  default: ;
               endcase
            end
         end

         // Frames advanced = accumulator / period, remainder stays
         ST_DIV_TIME: begin
            if (cnt_ff != '0) begin
               rem_in = take ? rem_sub : rem_shift;
               quo_in = {quo_ff[DW-2:0], take};
               dvd_in = {dvd_ff[DW-2:0], 1'b0};
               cnt_in = cnt_ff - CNT_W'(1);
            end else if (quo_ff != '0) begin
               acc_in = ACC_W'(rem_ff[TPF_W-1:0]);
               if (cfg_ff.loop_enable) begin
                  dvd_in = adv;
                  quo_in = '0;
                  rem_in = '0;
                  dsr_in = TPF_W'(cur_count);
                  cnt_in = CNT_W'(DW);
               end else if (adv >= DW'(last_frame)) begin
                  // one-shot end
                  frame_in   = last_frame;
                  playing_in = 1'b0;
                  acc_in     = '0;
               end else begin
                  frame_in = adv[FRAME_W-1:0];
               end
            end
         end

         // Loop wrap: (frame + n) mod count
         ST_DIV_WRAP: begin
            if (cnt_ff != '0) begin
               rem_in = take ? rem_sub : rem_shift;
               quo_in = {quo_ff[DW-2:0], take};
               dvd_in = {dvd_ff[DW-2:0], 1'b0};
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               frame_in = rem_ff[FRAME_W-1:0];
            end
         end

         // Atlas index into column and row
         ST_LOAD_CELL: begin
            dvd_in = {atlas, {(DW - ATLAS_W){1'b0}}};
            quo_in = '0;
            rem_in = '0;
            dsr_in = TPF_W'(cur_cols);
            cnt_in = CNT_W'(ATLAS_W);
         end

         ST_DIV_CELL: begin
            if (cnt_ff != '0) begin
               rem_in = take ? rem_sub : rem_shift;
               quo_in = {quo_ff[DW-2:0], take};
               dvd_in = {dvd_ff[DW-2:0], 1'b0};
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end

         // Load the response register once it is free
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = frame_ff;
               rsp_atlas_in = atlas;
               rsp_col_in   = cur_valid ? rem_ff[CELL_W-1:0] : '0;
               rsp_row_in   = cur_valid ? quo_ff[CELL_W-1:0] : '0;
               rsp_play_in  = playing_ff;
               rsp_sheet_in = cur_valid;
               rsp_chg_in   = cur_valid && (frame_ff != before_ff);
            end
         end

         default: ;
      endcase

      // Any register write reselects the initial frame
      if (csr_hit) begin
         frame_in = clamp_frame(cfg_in.initial_frame, cfg_in.frame_count);
         acc_in   = '0;
         if (!sheet_ok(cfg_in)) playing_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cfg_ff       <= '{frame_count: COUNT_W'(1), first_frame: '0, initial_frame: '0,
                           loop_enable: 1'b1, ticks_per_frame: '0, sheet_columns: '0,
                           sheet_rows: '0};
         frame_ff     <= '0;
         acc_ff       <= '0;
         playing_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cfg_ff       <= cfg_in;
         frame_ff     <= frame_in;
         acc_ff       <= acc_in;
         playing_ff   <= playing_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      before_ff    <= before_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dsr_ff       <= dsr_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_atlas_ff <= rsp_atlas_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_play_ff  <= rsp_play_in;
      rsp_sheet_ff <= rsp_sheet_in;
      rsp_chg_ff   <= rsp_chg_in;
   end

   // Port drive
   assign req_ch.ready         = (st_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.frame_now     = rsp_frame_ff;
   assign rsp_ch.atlas_index   = rsp_atlas_ff;
   assign rsp_ch.cell_column   = rsp_col_ff;
   assign rsp_ch.cell_row      = rsp_row_ff;
   assign rsp_ch.is_playing    = rsp_play_ff;
   assign rsp_ch.sheet_valid   = rsp_sheet_ff;
   assign rsp_ch.frame_changed = rsp_chg_ff;

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request accepted while a previous one is still in work");

   a_frame_in_range: assert property (@(posedge clock) disable iff (reset)
      frame_ff <= last_frame)
      else $error("current frame beyond the last frame");

   a_acc_below_period: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_IDLE) && (cfg_ff.ticks_per_frame != '0)) |->
      (acc_ff < ACC_W'(cfg_ff.ticks_per_frame)))
      else $error("time accumulator holds a whole frame period while idle");

   a_resp_from_resp_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_RESP))
      else $error("response raised outside the response state");

endmodule

>>> verif/sfs_checker.sv
// sfs_checker: response predictor and scoreboard for the sprite flipbook sequencer.
// Watches the request, response and CSR ports; depends on sfs_pkg and sfs_req_if / sfs_rsp_if.
`timescale 1ns / 1ps

module sfs_checker
   import sfs_pkg::*;
#(
   parameter int MAX_CELLS  = 4096,
   parameter int DELTA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   sfs_req_if                   req_mon,
   sfs_rsp_if                   rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   pending
);

   // One response as the sequencer presents it
   typedef struct packed {
      logic [FRAME_W-1:0] frame_now;
      logic [ATLAS_W-1:0] atlas_index;
      logic [CELL_W-1:0]  cell_column;
      logic [CELL_W-1:0]  cell_row;
      logic               is_playing;
      logic               sheet_valid;
      logic               frame_changed;
   } sprite_view_type;

   // Shadow registers and animation state
   cfg_type            regs;
   logic [FRAME_W-1:0] frame_pos;
   longint unsigned    tick_acc;
   logic               playing;
   sprite_view_type    expected_views[$];

   // Frame count in use: zero reads as one, top clipped
   function automatic int unsigned frame_total();
      int unsigned c;
      c = regs.frame_count;
      if (c == 0) c = 1;
      if (c > FRAME_LIMIT) c = FRAME_LIMIT;
      return c;
   endfunction

   function automatic int unsigned clip_side(input logic [DIM_W-1:0] d);
      return (int'(d) > DIM_LIMIT) ? DIM_LIMIT : d;
   endfunction

   function automatic logic [FRAME_W-1:0] limit_frame(input int unsigned f);
      int unsigned last;
      last = frame_total() - 1;
      return FRAME_W'((f > last) ? last : f);
   endfunction

   // Animation must fit in the sheet, cell count capped at MAX_CELLS
   function automatic bit sheet_fits();
      int unsigned cols, rows, cells;
      cols = clip_side(regs.sheet_columns);
      rows = clip_side(regs.sheet_rows);
      if (cols == 0 || rows == 0) return 1'b0;
      cells = cols * rows;
      if (cells > MAX_CELLS) cells = MAX_CELLS;
      return (regs.first_frame + frame_total()) <= cells;
   endfunction

   // Any register write reloads the initial frame and clears the accumulator
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_W-1:0] data);
      case (idx)
         CSR_FRAME_COUNT:     regs.frame_count     = data[COUNT_W-1:0];
         CSR_FIRST_FRAME:     regs.first_frame     = data[FRAME_W-1:0];
         CSR_INITIAL_FRAME:   regs.initial_frame   = data[FRAME_W-1:0];
         CSR_LOOP_ENABLE:     regs.loop_enable     = data[0];
         CSR_TICKS_PER_FRAME: regs.ticks_per_frame = data[TPF_W-1:0];
         CSR_SHEET_COLUMNS:   regs.sheet_columns   = data[DIM_W-1:0];
         CSR_SHEET_ROWS:      regs.sheet_rows      = data[DIM_W-1:0];
         default:             return;
      endcase
      frame_pos = limit_frame(regs.initial_frame);
      tick_acc  = 0;
      if (!sheet_fits()) playing = 1'b0;
   endfunction

   // Elapsed time: whole periods advance the frame, wrap or end the one-shot
   function automatic void advance_ticks(input longint unsigned delta);
      longint unsigned periods, pos;
      int unsigned     total;
      total = frame_total();
      if (!playing || delta == 0 || !sheet_fits()) return;
      if (total <= 1 || regs.ticks_per_frame == 0) return;
      tick_acc += delta;
      periods = tick_acc / regs.ticks_per_frame;
      if (periods == 0) return;
      tick_acc = tick_acc % regs.ticks_per_frame;
      pos = frame_pos + periods;
      if (regs.loop_enable) begin
         frame_pos = FRAME_W'(pos % total);
      end else if (pos >= total - 1) begin
         frame_pos = FRAME_W'(total - 1);
         playing   = 1'b0;
         tick_acc  = 0;
      end else begin
         frame_pos = FRAME_W'(pos);
      end
   endfunction

   // Apply one request and build the response it should produce
   function automatic sprite_view_type predict_step(input logic [OP_W-1:0] op,
                                                    input logic [DELTA_BITS-1:0] delta,
                                                    input logic [FRAME_W-1:0] want);
      sprite_view_type    v;
      logic [FRAME_W-1:0] prior;
      logic [ATLAS_W-1:0] atlas;
      int unsigned        cols;
      bit                 fits;
      prior = frame_pos;
      case (op)
         OP_TICK: advance_ticks(delta);
         OP_PLAY: begin
            frame_pos = limit_frame(frame_pos);
            // finished one-shot restarts from the top
            if (sheet_fits() && !regs.loop_enable && frame_pos + 1 >= frame_total()) begin
               frame_pos = '0;
               tick_acc  = 0;
            end
            playing = 1'b1;
         end
         OP_PAUSE: playing = 1'b0;
         OP_STOP: begin
            playing   = 1'b0;
            tick_acc  = 0;
            frame_pos = limit_frame(regs.initial_frame);
         end
         OP_SET_FRAME: begin
            tick_acc  = 0;
            frame_pos = limit_frame(want);
         end
         default: ;
      endcase

      fits  = sheet_fits();
      atlas = ATLAS_W'(regs.first_frame) + ATLAS_W'(frame_pos);
      cols  = clip_side(regs.sheet_columns);
      v.frame_now   = frame_pos;
      v.atlas_index = atlas;
      if (fits && cols != 0) begin
         v.cell_column = CELL_W'(atlas % cols);
         v.cell_row    = CELL_W'(atlas / cols);
      end else begin
         v.cell_column = '0;
         v.cell_row    = '0;
      end
      v.is_playing    = playing;
      v.sheet_valid   = fits;
      v.frame_changed = fits && (frame_pos != prior);
      return v;
   endfunction

   // Track CSR writes and requests, compare each response with the oldest prediction
   always @(posedge clock) begin
      sprite_view_type got, want, guess;
      if (reset) begin
         regs = '0;
         regs.frame_count = COUNT_W'(1);
         regs.loop_enable = 1'b1;
         frame_pos  = '0;
         tick_acc   = 0;
         playing    = 1'b0;
         mismatches = 0;
         expected_views.delete();
      end else begin
         if (csr_we) apply_register(csr_index, csr_wdata);
         if (req_mon.valid && req_mon.ready) begin
            guess = predict_step(req_mon.op, req_mon.tick_delta, req_mon.frame_request);
            expected_views.insert(expected_views.size(), guess);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.frame_now, rsp_mon.atlas_index, rsp_mon.cell_column,
                   rsp_mon.cell_row, rsp_mon.is_playing, rsp_mon.sheet_valid,
                   rsp_mon.frame_changed};
            if (expected_views.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response with no request outstanding: frame %0d atlas %0d",
                           $realtime, got.frame_now, got.atlas_index);
               mismatches++;
            end else begin
               want = expected_views.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $write("%0t: response differs (expected/actual): frame %0d/%0d ",
                            $realtime, want.frame_now, got.frame_now);
                     $display("atlas %0d/%0d col %0d/%0d row %0d/%0d playing %0b/%0b %s",
                              want.atlas_index, got.atlas_index,
                              want.cell_column, got.cell_column,
                              want.cell_row, got.cell_row,
                              want.is_playing, got.is_playing, "");
                     $display("   valid %0b/%0b changed %0b/%0b",
                              want.sheet_valid, got.sheet_valid,
                              want.frame_changed, got.frame_changed);
                  end
                  mismatches++;
               end
            end
         end
      end
      pending = expected_views.size();
   end

endmodule

>>> verif/tb_top.sv
// tb_top: clock, reset and request/CSR stimulus for the sprite flipbook sequencer, plus verdict.
// Depends on sfs_pkg, the sfs channel interfaces, the sequencer top and sfs_checker.
`timescale 1ns / 1ps

module tb_top;
   import sfs_pkg::*;

   localparam int CELL_CAP    = 4096;
   localparam int DELTA_W     = 16;
   localparam int ITEM_TARGET = 1150;
   localparam int CALM_TAIL   = 150;
   localparam int DELTA_MAX   = (1 << DELTA_W) - 1;
   localparam int FRAME_MAX   = (1 << FRAME_W) - 1;
   localparam int TPF_MAX     = (1 << TPF_W) - 1;

   // Opcodes and register index the package leaves unnamed
   localparam logic [OP_W-1:0]      OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0]      OP_SPARE_B = 3'd6;
   localparam logic [OP_W-1:0]      OP_SPARE_C = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 3'd7;

   logic                 clock = 1'b1;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   mismatches;
   int                   pending;
   bit                   bursty;
   int                   items_sent;
   int unsigned          anim_frames;

   sfs_req_if #(.DELTA_BITS(DELTA_W)) req_ch ();
   sfs_rsp_if rsp_ch ();

   sprite_flipbook_frame_sequencer_top #(
      .MAX_CELLS (CELL_CAP),
      .DELTA_BITS(DELTA_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   sfs_checker #(
      .MAX_CELLS (CELL_CAP),
      .DELTA_BITS(DELTA_W)
   ) u_check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mismatches(mismatches),
      .pending   (pending)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b0;
      #1 clock = 1'b1;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Response back-pressure: bursts of stall or accept, always ready when calm
   initial begin
      int burst;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         burst = $urandom_range(1, 10);
         if (bursty && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         repeat (burst - 1) @(negedge clock);
      end
   end

   // Present one request, optionally after an idle burst; returns on a falling edge
   task automatic send_request(input logic [OP_W-1:0] op, input int unsigned delta,
                               input int unsigned want);
      if (bursty && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.tick_delta    <= DELTA_W'(delta);
      req_ch.frame_request <= FRAME_W'(want);
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Stop requesting and wait until every response is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
   endtask

   // Write the whole register set; block must be idle
   task automatic program_sheet(input int unsigned count, input int unsigned first,
                                input int unsigned init, input int unsigned loop_on,
                                input int unsigned tpf, input int unsigned cols,
                                input int unsigned rows);
      write_reg(CSR_FRAME_COUNT, count);
      write_reg(CSR_FIRST_FRAME, first);
      write_reg(CSR_INITIAL_FRAME, init);
      write_reg(CSR_LOOP_ENABLE, loop_on);
      write_reg(CSR_TICKS_PER_FRAME, tpf);
      write_reg(CSR_SHEET_COLUMNS, cols);
      write_reg(CSR_SHEET_ROWS, rows);
      @(negedge clock);
      csr_we <= 1'b0;
      anim_frames = (count == 0) ? 1 : (count > FRAME_LIMIT) ? FRAME_LIMIT : count;
   endtask

   // Mostly ticks with deltas near the frame period, mixed with commands
   task automatic random_request(input int unsigned tpf);
      logic [OP_W-1:0] op;
      int unsigned     pick, span, delta, want;
      pick = $urandom_range(0, 99);
      if (pick < 60)      op = OP_TICK;
      else if (pick < 70) op = OP_PLAY;
      else if (pick < 75) op = OP_PAUSE;
      else if (pick < 80) op = OP_STOP;
      else if (pick < 91) op = OP_SET_FRAME;
      else if (pick < 94) op = OP_SPARE_A;
      else if (pick < 97) op = OP_SPARE_B;
      else                op = OP_SPARE_C;
      span = (tpf == 0 || tpf > 20000) ? DELTA_MAX : 3 * tpf + 1;
      pick = $urandom_range(0, 9);
      if (pick == 0)     delta = 0;
      else if (pick < 6) delta = $urandom_range(1, span);
      else               delta = $urandom_range(0, DELTA_MAX);
      want = $urandom_range(0, 1) ? $urandom_range(0, anim_frames) : $urandom_range(0, FRAME_MAX);
      send_request(op, delta, want);
   endtask

   task automatic run_phase(input int unsigned items, input int unsigned tpf);
      send_request(OP_PLAY, 0, 0);
      repeat (items) random_request(tpf);
   endtask

   // New random sheet, mostly a valid one so that ticks advance
   task automatic random_phase(input int unsigned items, input bit wild);
      int unsigned cols, rows, cells, lo, hi, cnt, first, init, tpf, pick;
      int unsigned cnt_w, cols_w, rows_w;
      pick = $urandom_range(0, 19);
      if (pick == 0)      tpf = 0;
      else if (pick == 1) tpf = $urandom_range(0, TPF_MAX);
      else                tpf = $urandom_range(1, 1 << $urandom_range(0, 12));
      if (wild) begin
         cnt_w  = $urandom_range(0, (1 << COUNT_W) - 1);
         first  = $urandom_range(0, FRAME_MAX);
         init   = $urandom_range(0, FRAME_MAX);
         cols_w = $urandom_range(0, (1 << DIM_W) - 1);
         rows_w = $urandom_range(0, (1 << DIM_W) - 1);
      end else begin
         cols  = $urandom_range(1, DIM_LIMIT);
         rows  = $urandom_range(1, DIM_LIMIT);
         cells = cols * rows;
         if (cells > CELL_CAP) cells = CELL_CAP;
         lo  = (cells >= 2) ? 2 : 1;
         hi  = ($urandom_range(0, 4) == 0 || cells < 24) ? cells : 24;
         cnt = $urandom_range(lo, hi);
         first = $urandom_range(0, cells - cnt);
         init  = $urandom_range(0, 1) ? $urandom_range(0, cnt - 1) : $urandom_range(0, FRAME_MAX);
         // out-of-range encodings that clip to the same value
         cnt_w = cnt;
         if (cnt == FRAME_LIMIT && $urandom_range(0, 1))
            cnt_w = $urandom_range(FRAME_LIMIT, (1 << COUNT_W) - 1);
         if (cnt == 1 && $urandom_range(0, 1)) cnt_w = 0;
         cols_w = (cols == DIM_LIMIT && $urandom_range(0, 1)) ?
                  $urandom_range(DIM_LIMIT, (1 << DIM_W) - 1) : cols;
         rows_w = (rows == DIM_LIMIT && $urandom_range(0, 1)) ?
                  $urandom_range(DIM_LIMIT, (1 << DIM_W) - 1) : rows;
      end
      drain();
      program_sheet(cnt_w, first, init, $urandom_range(0, 1), tpf, cols_w, rows_w);
      run_phase(items, tpf);
   endtask

   // Main sequence
   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.op            = '0;
      req_ch.tick_delta    = '0;
      req_ch.frame_request = '0;
      bursty               = 1'b1;
      items_sent           = 0;
      anim_frames          = 1;
      repeat (13) @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: no sheet, single frame
      send_request(OP_TICK, DELTA_MAX, 0);
      send_request(OP_PLAY, 0, 0);
      send_request(OP_TICK, 1, 0);
      send_request(OP_SPARE_C, 0, 0);

      // Five-frame one-shot on a 4x2 sheet starting at cell 3
      drain();
      program_sheet(5, 3, 2, 0, 3, 4, 2);
      send_request(OP_PLAY, 0, 0);
      send_request(OP_TICK, 0, 0);
      send_request(OP_TICK, 2, 0);
      send_request(OP_TICK, 1, 0);
      send_request(OP_TICK, DELTA_MAX, 0);
      send_request(OP_TICK, 5, 0);
      send_request(OP_PLAY, 0, 0);
      send_request(OP_PAUSE, 0, 0);
      send_request(OP_TICK, 9, 0);
      send_request(OP_SET_FRAME, 0, FRAME_MAX);
      send_request(OP_STOP, 0, 0);
      send_request(OP_SPARE_A, 0, 0);
      send_request(OP_SPARE_B, 0, 0);

      // Switch to looping; the unused index must change nothing
      drain();
      write_reg(CSR_LOOP_ENABLE, 1);
      write_reg(CSR_SPARE, $urandom_range(0, TPF_MAX));
      @(negedge clock);
      csr_we <= 1'b0;
      send_request(OP_PLAY, 0, 0);
      send_request(OP_TICK, DELTA_MAX, 0);
      send_request(OP_TICK, 3, 0);
      send_request(OP_SET_FRAME, 0, 0);
      send_request(OP_TICK, 2, 0);
      send_request(OP_TICK, 1, 0);

      // Extreme settings
      drain();
      program_sheet((1 << COUNT_W) - 1, 0, FRAME_MAX, 1, 1, (1 << DIM_W) - 1, (1 << DIM_W) - 1);
      run_phase(20, 1);
      drain();
      program_sheet(FRAME_LIMIT, 0, 0, 0, TPF_MAX, DIM_LIMIT, DIM_LIMIT);
      run_phase(20, TPF_MAX);
      drain();
      program_sheet(0, FRAME_MAX, FRAME_MAX, 1, 5, DIM_LIMIT, DIM_LIMIT);
      run_phase(20, 5);
      drain();
      program_sheet(FRAME_LIMIT, FRAME_MAX, FRAME_MAX, 0, 0, 0, (1 << DIM_W) - 1);
      run_phase(20, 0);
      drain();
      program_sheet(2, 0, 1, 0, 1, 1, 2);
      run_phase(20, 1);

      // Random sheets; idling stops for the tail of the run
      while (items_sent < ITEM_TARGET) begin
         bursty = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 4) != 0);
         random_phase($urandom_range(40, 110), $urandom_range(0, 6) == 0);
      end

      drain();
      repeat (100) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
